FILE: design/pafit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafit_pkg
// shared types, codes and constants of the partition allocator
// ----------------------------------------------------------------------------
package pafit_pkg;

  localparam int MAX_PARTS_DEF = 32;
  localparam int BASE_W        = 20;
  localparam int BYTES_W       = 21;
  localparam int OWNER_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 21;

  localparam logic [BYTES_W-1:0] MEM_MAX   = 21'd1048576;
  localparam logic [BYTES_W-1:0] MEM_RESET = 21'd4096;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOOWNER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_SPARE = 2'd3
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_POLICY = 2'd0,
    REG_MEM_SIZE   = 2'd1,
    REG_SPARE2     = 2'd2,
    REG_SPARE3     = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DEC,
    S_NXT,
    S_MERGE,
    S_SHIFT,
    S_TAIL,
    S_SPLIT,
    S_OWN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [BYTES_W-1:0] bytes;
    logic               used;
    logic [OWNER_W-1:0] owner;
  } entry_t;

endpackage

FILE: design/alloc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_req_if
// request channel: operation, owner and size
// ----------------------------------------------------------------------------
interface alloc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] owner_id;
  logic [20:0] request_size;

  modport source (output valid, operation, owner_id, request_size, input ready);
  modport sink (input valid, operation, owner_id, request_size, output ready);
endinterface

FILE: design/alloc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_rsp_if
// result channel: status and the affected partition
// ----------------------------------------------------------------------------
interface alloc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] part_base;
  logic [19:0] part_limit;
  logic [20:0] part_bytes;

  modport source (output valid, status, part_base, part_limit, part_bytes, input ready);
  modport sink (input valid, status, part_base, part_limit, part_bytes, output ready);
endinterface

FILE: design/alloc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface alloc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pafit_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafit_mem
// partition table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pafit_mem #(
  parameter int DEPTH = pafit_pkg::MAX_PARTS_DEF,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output pafit_pkg::entry_t rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  pafit_pkg::entry_t wr_data
);
  import pafit_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: design/partition_allocator_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_allocator_fit
// dynamic partition allocator with first, best and worst fit and coalescing
// ----------------------------------------------------------------------------
// usage
//   req : operation, owner_id, request_size; taken when valid and ready
//   rsp : status, part_base, part_limit, part_bytes; one result per request
//   cfg : index 0 fit_policy, index 1 mem_size; write only while idle.
//         a mem_size write drops every allocation and rebuilds the table
// timing
//   the table lives in one memory with a registered read; a request scans
//   it one entry per cycle, then an insert or removal moves one entry per
//   cycle behind the split or merge point, plus bookkeeping states; an
//   unknown operation or a zero-size allocation goes straight to the
//   result.
//   one request is worked on at a time
// reset
//   synchronous; the init state after reset writes entry 0 as a single free
//   partition of mem_size bytes, then req is taken
// stall
//   the result waits in an output register; the next request may be taken
//   and scanned, and only its hand-over waits for rsp.ready
// ----------------------------------------------------------------------------
module partition_allocator_fit #(
  parameter int MAX_PARTS = pafit_pkg::MAX_PARTS_DEF
) (
  input logic clk,
  input logic rst,
  alloc_req_if.sink   req,
  alloc_rsp_if.source rsp,
  alloc_cfg_if.sink   cfg
);
  import pafit_pkg::*;

  localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PARTS);

  // control state
  state_t state, state_next;
  logic [1:0]         policy;
  logic [BYTES_W-1:0] msize;
  logic [CW-1:0]      count;

  // request held for the whole operation
  op_t                op_r;
  logic [OWNER_W-1:0] id_r;
  logic [BYTES_W-1:0] size_r;

  // scan bookkeeping
  logic [IW-1:0] chk;
  logic          have;
  entry_t        pick;       // chosen free entry, or the owner's entry
  logic [IW-1:0] pick_idx;
  entry_t        prev_e;     // entry just before the one being checked
  entry_t        prev_keep;  // left neighbour of the owner's entry
  logic          nf;         // right neighbour is free
  logic [BYTES_W-1:0] nbytes;

  // table shift
  logic [IW-1:0] sh_idx, sh_end, sh_wa;
  logic          sh_up, sh_val;
  logic [1:0]    sh_amt;

  // result
  status_t            res_status;
  logic [BASE_W-1:0]  res_base;
  logic [BYTES_W-1:0] res_bytes;

  // memory port
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  pafit_mem #(.DEPTH(MAX_PARTS), .AW(IW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  logic req_acc, cfg_acc, out_free;
  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid;
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign req_acc   = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // scan decisions on the entry that has just come out of the memory
  logic last, hit, take, match, pol_first, stop;
  always_comb begin
    pol_first = (policy != FIT_BEST) && (policy != FIT_WORST);
    last  = (CW'(chk) == count - CW'(1));
    hit   = !rd_data.used && (rd_data.bytes >= size_r);
    take  = hit && (!have ||
             ((policy == FIT_BEST)  && (rd_data.bytes < pick.bytes)) ||
             ((policy == FIT_WORST) && (rd_data.bytes > pick.bytes)));
    match = rd_data.used && (rd_data.owner == id_r);
    if (op_r == OP_ALLOC) begin
      stop = last || (hit && !have && pol_first);
    end else begin
      stop = last || match;
    end
  end

  // release merge arithmetic
  logic               pf;
  logic [BYTES_W-1:0] mbytes;
  logic [BASE_W-1:0]  mbase;
  logic [IW-1:0]      widx;
  logic [1:0]         rmv;
  logic [CW-1:0]      sh_start;
  logic               need_dn;
  always_comb begin
    pf       = (pick_idx != '0) && !prev_keep.used;
    mbytes   = pick.bytes + (nf ? nbytes : '0) + (pf ? prev_keep.bytes : '0);
    mbase    = pf ? prev_keep.base : pick.base;
    widx     = pf ? IW'(pick_idx - 1'b1) : pick_idx;
    rmv      = {1'b0, nf} + {1'b0, pf};
    sh_start = CW'(pick_idx) + CW'(1) + CW'(nf);
    need_dn  = (rmv != 2'd0) && (sh_start < count);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (req_acc) begin
          if ((op_t'(req.operation) == OP_NONE) ||
              ((op_t'(req.operation) == OP_ALLOC) && (req.request_size == '0))) begin
            state_next = S_RESP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: if (stop) state_next = S_DEC;
      S_DEC: begin
        priority case (op_r)
          OP_ALLOC: begin
            if (!have || pick.bytes == size_r) begin
              state_next = S_RESP;
            end else if (count >= MAXC) begin
              state_next = S_RESP;
            end else if (CW'(pick_idx) == count - CW'(1)) begin
              state_next = S_SPLIT;
            end else begin
              state_next = S_SHIFT;
            end
          end
          OP_RELEASE: begin
            if (!have) begin
              state_next = S_RESP;
            end else if (CW'(pick_idx) + CW'(1) == count) begin
              state_next = S_MERGE;
            end else begin
              state_next = S_NXT;
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_NXT:   state_next = S_MERGE;
      S_MERGE: state_next = need_dn ? S_SHIFT : S_RESP;
      S_SHIFT: if (sh_idx == sh_end) state_next = S_TAIL;
      S_TAIL:  state_next = sh_up ? S_SPLIT : S_RESP;
      S_SPLIT: state_next = S_OWN;
      S_OWN:   state_next = S_RESP;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
    if (cfg_acc && (reg_idx_t'(cfg.index) == REG_MEM_SIZE)) begin
      state_next = S_INIT;
    end
  end

  // memory accesses
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_INIT: begin
        wr_en         = 1'b1;
        wr_data.bytes = msize;
      end
      S_IDLE: begin
        rd_en = req_acc;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = IW'(chk + 1'b1);
      end
      S_DEC: begin
        rd_en   = 1'b1;
        rd_addr = IW'(pick_idx + 1'b1);
        if ((op_r == OP_ALLOC) && have && (pick.bytes == size_r)) begin
          wr_en   = 1'b1;
          wr_addr = pick_idx;
          wr_data = '{base: pick.base, bytes: size_r, used: 1'b1, owner: id_r};
        end
      end
      S_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = widx;
        wr_data = '{base: mbase, bytes: mbytes, used: 1'b0, owner: '0};
      end
      S_SHIFT: begin
        rd_en   = 1'b1;
        rd_addr = sh_idx;
        wr_en   = sh_val;
        wr_addr = sh_wa;
        wr_data = rd_data;
      end
      S_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = sh_wa;
        wr_data = rd_data;
      end
      S_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = IW'(pick_idx + 1'b1);
        wr_data = '{base: BASE_W'({1'b0, pick.base} + size_r),
                    bytes: pick.bytes - size_r, used: 1'b0, owner: '0};
      end
      S_OWN: begin
        wr_en   = 1'b1;
        wr_addr = pick_idx;
        wr_data = '{base: pick.base, bytes: size_r, used: 1'b1, owner: id_r};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      policy <= FIT_FIRST;
      msize  <= MEM_RESET;
      count  <= CW'(1);
      sh_val <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        unique case (reg_idx_t'(cfg.index))
          REG_FIT_POLICY: policy <= cfg.data[1:0];
          REG_MEM_SIZE: begin
            if (cfg.data == '0) begin
              msize <= BYTES_W'(1);
            end else if (cfg.data > MEM_MAX) begin
              msize <= MEM_MAX;
            end else begin
              msize <= cfg.data;
            end
          end
          default: ;
        endcase
      end
      if (state == S_INIT) count <= CW'(1);
      if (state == S_SPLIT) count <= count + CW'(1);
      if (state == S_MERGE) count <= count - CW'(rmv);
      if (state == S_SHIFT) sh_val <= 1'b1;
      if (state == S_TAIL) sh_val <= 1'b0;
      if ((state == S_RESP) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          op_r   <= op_t'(req.operation);
          id_r   <= req.owner_id;
          size_r <= req.request_size;
          chk    <= '0;
          have   <= 1'b0;
          res_status <= (op_t'(req.operation) == OP_ALLOC) ? ST_NOFIT : ST_NOOWNER;
        end
      end
      S_SCAN: begin
        chk    <= IW'(chk + 1'b1);
        prev_e <= rd_data;
        if (op_r == OP_ALLOC) begin
          if (take) begin
            have     <= 1'b1;
            pick     <= rd_data;
            pick_idx <= chk;
          end
        end else if (match && !have) begin
          have      <= 1'b1;
          pick      <= rd_data;
          pick_idx  <= chk;
          prev_keep <= prev_e;
        end
      end
      S_DEC: begin
        nf <= 1'b0;
        res_base  <= pick.base;
        res_bytes <= (op_r == OP_ALLOC) ? size_r : pick.bytes;
        if (!have) begin
          res_status <= (op_r == OP_ALLOC) ? ST_NOFIT : ST_NOOWNER;
        end else if ((op_r == OP_ALLOC) && (pick.bytes != size_r) && (count >= MAXC)) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
        end
        // insert: move entries count-1 down to pick+1 up by one
        sh_up  <= 1'b1;
        sh_amt <= 2'd1;
        sh_idx <= IW'(count - CW'(1));
        sh_end <= IW'(pick_idx + 1'b1);
      end
      S_NXT: begin
        nf     <= !rd_data.used;
        nbytes <= rd_data.bytes;
      end
      S_MERGE: begin
        res_base  <= mbase;
        res_bytes <= mbytes;
        // removal: move entries behind the merged ones down
        sh_up  <= 1'b0;
        sh_amt <= rmv;
        sh_idx <= IW'(sh_start);
        sh_end <= IW'(count - CW'(1));
      end
      S_SHIFT: begin
        sh_wa  <= sh_up ? IW'(sh_idx + 1'b1) : IW'(sh_idx - sh_amt);
        sh_idx <= sh_up ? IW'(sh_idx - 1'b1) : IW'(sh_idx + 1'b1);
      end
      S_RESP: begin
        if (out_free) begin
          rsp.status <= res_status;
          if (res_status == ST_OK) begin
            rsp.part_base  <= res_base;
            rsp.part_limit <= BASE_W'({1'b0, res_base} + res_bytes - BYTES_W'(1));
            rsp.part_bytes <= res_bytes;
          end else begin
            rsp.part_base  <= '0;
            rsp.part_limit <= '0;
            rsp.part_bytes <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // table never empty and never beyond its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(1)) && (count <= MAXC))
    else $error("partition count out of range");

  // a chosen partition is free and large enough
  a_pick_fits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DEC) && (op_r == OP_ALLOC) && have) |->
      (!pick.used && (pick.bytes >= size_r)))
    else $error("allocation picked an unusable partition");

  // an insert never writes further than one entry past the current end of the table
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && sh_val && sh_up) |-> (CW'(sh_wa) <= count))
    else $error("table shift out of bounds");

  // a taken request always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> (state != S_IDLE))
    else $error("request taken but not worked on");
endmodule
